/* rtl/gpn_pkg.sv */
// Shared types, constants and the button remap function of the gamepad normalizer.
package gpn_pkg;

    localparam logic [14:0] AXIS_FULL = 15'h7FFF;
    localparam logic [7:0]  RAW_FULL  = 8'hFF;

    localparam logic [14:0] LEFT_DZ_RESET   = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RESET  = 15'd8689;
    localparam logic [7:0]  TRIG_THR_RESET  = 8'd30;

    localparam logic [1:0] CFG_LEFT_DZ   = 2'd0;
    localparam logic [1:0] CFG_RIGHT_DZ  = 2'd1;
    localparam logic [1:0] CFG_TRIG_THR  = 2'd2;

    localparam int BTN_L2 = 12;
    localparam int BTN_R2 = 13;

    // One classified report waiting for the arithmetic back end.
    typedef struct packed {
        logic [15:0]        buttons;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [7:0]         ldiff;
        logic [7:0]         rdiff;
        logic [7:0]         span;
    } gpn_item_t;

    typedef enum logic {B_IDLE, B_RUN} back_state_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_CHK, S_SQRT, S_PROD, S_NUM, S_DIV
    } stick_state_t;

    typedef enum logic {T_IDLE, T_DIV} trig_state_t;

    // Native layout to canonical layout; L2 and R2 come from the triggers.
    function automatic logic [15:0] remap_buttons(input logic [15:0] nb);
        logic [15:0] b;
        b       = '0;
        b[0]    = nb[12];
        b[1]    = nb[13];
        b[2]    = nb[14];
        b[3]    = nb[15];
        b[4]    = nb[0];
        b[5]    = nb[1];
        b[6]    = nb[2];
        b[7]    = nb[3];
        b[8]    = nb[4];
        b[9]    = nb[5];
        b[10]   = nb[8];
        b[11]   = nb[9];
        b[14]   = nb[6];
        b[15]   = nb[7];
        return b;
    endfunction

endpackage

/* rtl/gamepad_report_normalizer.sv */
// Top level of the gamepad report normalizer: config registers, front end and back end.
//
// Usage: a raw controller report is presented on the input ports with start high; the
// request is taken at a rising edge where start is high and busy is low. Reports go into
// a short queue, so busy only rises when that queue is full. Each request yields one
// result, shown for exactly one cycle with result_valid high; the receiver cannot stall
// and must take it in that cycle.
// A report occupies the arithmetic back end for the 32-step bit-serial square root
// followed by the 16-step serial divide in each stick engine; the two sticks and both
// triggers run side by side, and the back end takes the next queued report only once
// all engines are done, then registers the result. A report whose sticks both sit inside
// their deadzones skips the root and the stick divides and waits only for the 15-step
// trigger divide.
// Configuration: cfg_valid/cfg_ready write channel with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 is the left deadzone, 1 the right deadzone, 2 the trigger
// threshold; other indexes are ignored and only the register's low bits are kept.
// Registers are to be written only while no request is in flight; the block does not enforce it.
// Reset: rst_n clears the queue and the engines and restores the register defaults.
module gamepad_report_normalizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        raw_buttons,
    input  logic signed [15:0] left_stick_x,
    input  logic signed [15:0] left_stick_y,
    input  logic signed [15:0] right_stick_x,
    input  logic signed [15:0] right_stick_y,
    input  logic [7:0]         left_trigger_raw,
    input  logic [7:0]         right_trigger_raw,
    output logic               result_valid,
    output logic [15:0]        button_bits,
    output logic signed [15:0] left_x,
    output logic signed [15:0] left_y,
    output logic signed [15:0] right_x,
    output logic signed [15:0] right_y,
    output logic [14:0]        left_trigger_level,
    output logic [14:0]        right_trigger_level,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import gpn_pkg::*;

    logic [14:0] left_dz_reg;
    logic [14:0] right_dz_reg;
    logic [7:0]  trig_thr_reg;
    logic        pop;
    logic        q_valid;
    gpn_item_t   q_item;

    assign cfg_ready = 1'b1;

    // The register file is always ready; writes land on the cycle they are offered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_dz_reg  <= LEFT_DZ_RESET;
            right_dz_reg <= RIGHT_DZ_RESET;
            trig_thr_reg <= TRIG_THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEFT_DZ:  left_dz_reg  <= cfg_data[14:0];
                CFG_RIGHT_DZ: right_dz_reg <= cfg_data[14:0];
                CFG_TRIG_THR: trig_thr_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // The front end classifies each request and parks it in the queue.
    gpn_front #(
        .QDEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .raw_buttons       (raw_buttons),
        .left_stick_x      (left_stick_x),
        .left_stick_y      (left_stick_y),
        .right_stick_x     (right_stick_x),
        .right_stick_y     (right_stick_y),
        .left_trigger_raw  (left_trigger_raw),
        .right_trigger_raw (right_trigger_raw),
        .trig_thr          (trig_thr_reg),
        .pop               (pop),
        .q_valid           (q_valid),
        .q_item            (q_item)
    );

    // The back end does the square roots and divides and drives the result ports.
    gpn_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_valid             (q_valid),
        .q_item              (q_item),
        .left_dz             (left_dz_reg),
        .right_dz            (right_dz_reg),
        .pop                 (pop),
        .result_valid        (result_valid),
        .button_bits         (button_bits),
        .left_x              (left_x),
        .left_y              (left_y),
        .right_x             (right_x),
        .right_y             (right_y),
        .left_trigger_level  (left_trigger_level),
        .right_trigger_level (right_trigger_level)
    );

endmodule

/* rtl/gpn_front.sv */
// Front end: accepts reports, classifies buttons and triggers, and queues them.
module gpn_front #(
    parameter int QDEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [15:0]         raw_buttons,
    input  logic signed [15:0]  left_stick_x,
    input  logic signed [15:0]  left_stick_y,
    input  logic signed [15:0]  right_stick_x,
    input  logic signed [15:0]  right_stick_y,
    input  logic [7:0]          left_trigger_raw,
    input  logic [7:0]          right_trigger_raw,
    input  logic [7:0]          trig_thr,
    input  logic                pop,
    output logic                q_valid,
    output gpn_pkg::gpn_item_t  q_item
);
    import gpn_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    gpn_item_t       mem [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push;
    logic            lp;
    logic            rp;
    gpn_item_t       item;

    // Triggers are classified here so the back end only divides.
    always_comb
    begin
        lp           = left_trigger_raw > trig_thr;
        rp           = right_trigger_raw > trig_thr;
        item.buttons = remap_buttons(raw_buttons);
        item.buttons[BTN_L2] = lp;
        item.buttons[BTN_R2] = rp;
        item.lx      = left_stick_x;
        item.ly      = left_stick_y;
        item.rx      = right_stick_x;
        item.ry      = right_stick_y;
        item.ldiff   = lp ? 8'(left_trigger_raw - trig_thr) : 8'd0;
        item.rdiff   = rp ? 8'(right_trigger_raw - trig_thr) : 8'd0;
        item.span    = 8'(RAW_FULL - trig_thr);
    end

    assign busy    = (count_reg == CW'(QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/gpn_stick.sv */
// Stick engine: radial deadzone, bit-serial square root and two serial divides.
module gpn_stick (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] x,
    input  logic signed [15:0] y,
    input  logic [14:0]        dz,
    output logic               busy,
    output logic signed [15:0] ox,
    output logic signed [15:0] oy
);
    import gpn_pkg::*;

    stick_state_t state_reg;
    stick_state_t state_next;

    logic        xneg_reg, yneg_reg;
    logic [15:0] ax_reg, ay_reg;
    logic [14:0] d_reg;
    logic [31:0] xx_reg, yy_reg;
    logic [29:0] dd_reg;
    logic [63:0] v_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic [46:0] den_reg, px_reg, py_reg;
    logic [63:0] nx_reg, ny_reg;
    logic [62:0] dsh_reg;
    logic [15:0] qx_reg, qy_reg;

    logic [31:0] q_sum;
    logic        zero;
    logic [34:0] cand;
    logic [34:0] trial;
    logic [31:0] mag;
    logic [30:0] excess;
    logic [14:0] range;
    logic [61:0] numx, numy;
    logic [47:0] den2;
    logic [15:0] satx, saty;

    always_comb
    begin
        q_sum  = xx_reg + yy_reg;
        zero   = (q_sum == '0) || (q_sum <= {2'b00, dd_reg}) || (d_reg == AXIS_FULL);
        cand   = {rem_reg[32:0], v_reg[63:62]};
        trial  = {1'b0, root_reg, 2'b01};
        mag    = (root_reg > {1'b0, AXIS_FULL, 16'h0000}) ? {1'b0, AXIS_FULL, 16'h0000}
                                                          : root_reg;
        excess = 31'(mag - {1'b0, d_reg, 16'h0000});
        range  = AXIS_FULL - d_reg;
        numx   = {px_reg, 15'h0000} - 62'(px_reg);
        numy   = {py_reg, 15'h0000} - 62'(py_reg);
        den2   = {den_reg, 1'b0};
        satx   = qx_reg[15] ? {1'b0, AXIS_FULL} : qx_reg;
        saty   = qy_reg[15] ? {1'b0, AXIS_FULL} : qy_reg;
    end

    assign busy = (state_reg != S_IDLE);
    assign ox   = xneg_reg ? 16'(-satx) : satx;
    assign oy   = yneg_reg ? 16'(-saty) : saty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_SQ;
            S_SQ:    state_next = S_CHK;
            S_CHK:   state_next = zero ? S_IDLE : S_SQRT;
            S_SQRT:  if (cnt_reg == 5'd31) state_next = S_PROD;
            S_PROD:  state_next = S_NUM;
            S_NUM:   state_next = S_DIV;
            S_DIV:   if (cnt_reg == 5'd15) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    xneg_reg <= x[15];
                    yneg_reg <= y[15];
                    ax_reg   <= x[15] ? 16'(-x) : 16'(x);
                    ay_reg   <= y[15] ? 16'(-y) : 16'(y);
                    d_reg    <= dz;
                end
            end
            S_SQ:
            begin
                xx_reg <= 32'(ax_reg) * 32'(ax_reg);
                yy_reg <= 32'(ay_reg) * 32'(ay_reg);
                dd_reg <= 30'(d_reg) * 30'(d_reg);
            end
            S_CHK:
            begin
                qx_reg   <= '0;
                qy_reg   <= '0;
                v_reg    <= {q_sum, 32'h0};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            S_SQRT:
            begin
                // One result bit of the square root per cycle.
                if (cand >= trial)
                begin
                    rem_reg  <= cand - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= cand;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                v_reg   <= {v_reg[61:0], 2'b00};
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_PROD:
            begin
                den_reg <= 47'(root_reg) * 47'(range);
                px_reg  <= 47'(ax_reg) * 47'(excess);
                py_reg  <= 47'(ay_reg) * 47'(excess);
            end
            S_NUM:
            begin
                // Rounded half up: (2*num + den) / (2*den).
                nx_reg  <= {numx, 1'b0} + 64'(den_reg);
                ny_reg  <= {numy, 1'b0} + 64'(den_reg);
                dsh_reg <= {den2, 15'h0000};
                cnt_reg <= '0;
            end
            S_DIV:
            begin
                // The top quotient bit flags a value that saturates.
                if (nx_reg >= 64'(dsh_reg))
                begin
                    nx_reg <= nx_reg - 64'(dsh_reg);
                    qx_reg <= {qx_reg[14:0], 1'b1};
                end
                else
                begin
                    qx_reg <= {qx_reg[14:0], 1'b0};
                end
                if (ny_reg >= 64'(dsh_reg))
                begin
                    ny_reg <= ny_reg - 64'(dsh_reg);
                    qy_reg <= {qy_reg[14:0], 1'b1};
                end
                else
                begin
                    qy_reg <= {qy_reg[14:0], 1'b0};
                end
                dsh_reg <= {1'b0, dsh_reg[62:1]};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/gpn_trig.sv */
// Trigger engine: serial divide of both trigger levels over a shared span.
module gpn_trig (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [7:0]  ldiff,
    input  logic [7:0]  rdiff,
    input  logic [7:0]  span,
    output logic        busy,
    output logic [14:0] llevel,
    output logic [14:0] rlevel
);
    import gpn_pkg::*;

    trig_state_t state_reg;
    trig_state_t state_next;

    logic [24:0] nl_reg, nr_reg;
    logic [22:0] dsh_reg;
    logic [14:0] ql_reg, qr_reg;
    logic        lz_reg, rz_reg;
    logic [3:0]  cnt_reg;
    logic [22:0] pl, pr;

    always_comb
    begin
        pl = {ldiff, 15'h0000} - 23'(ldiff);
        pr = {rdiff, 15'h0000} - 23'(rdiff);
    end

    assign busy   = (state_reg != T_IDLE);
    assign llevel = lz_reg ? '0 : ql_reg;
    assign rlevel = rz_reg ? '0 : qr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:  if (start) state_next = T_DIV;
            T_DIV:   if (cnt_reg == 4'd14) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    nl_reg  <= {pl, 1'b0} + 25'(span);
                    nr_reg  <= {pr, 1'b0} + 25'(span);
                    dsh_reg <= {span, 1'b0, 14'h0000};
                    lz_reg  <= (ldiff == '0);
                    rz_reg  <= (rdiff == '0);
                    ql_reg  <= '0;
                    qr_reg  <= '0;
                    cnt_reg <= '0;
                end
            end
            T_DIV:
            begin
                if (nl_reg >= 25'(dsh_reg))
                begin
                    nl_reg <= nl_reg - 25'(dsh_reg);
                    ql_reg <= {ql_reg[13:0], 1'b1};
                end
                else
                begin
                    ql_reg <= {ql_reg[13:0], 1'b0};
                end
                if (nr_reg >= 25'(dsh_reg))
                begin
                    nr_reg <= nr_reg - 25'(dsh_reg);
                    qr_reg <= {qr_reg[13:0], 1'b1};
                end
                else
                begin
                    qr_reg <= {qr_reg[13:0], 1'b0};
                end
                dsh_reg <= {1'b0, dsh_reg[22:1]};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/gpn_back.sv */
// Back end: takes queued requests, runs the stick and trigger engines, emits results.
module gpn_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  gpn_pkg::gpn_item_t q_item,
    input  logic [14:0]        left_dz,
    input  logic [14:0]        right_dz,
    output logic               pop,
    output logic               result_valid,
    output logic [15:0]        button_bits,
    output logic signed [15:0] left_x,
    output logic signed [15:0] left_y,
    output logic signed [15:0] right_x,
    output logic signed [15:0] right_y,
    output logic [14:0]        left_trigger_level,
    output logic [14:0]        right_trigger_level
);
    import gpn_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic               lbusy, rbusy, tbusy;
    logic               all_done;
    logic signed [15:0] lx, ly, rx, ry;
    logic [14:0]        ll, rl;
    logic [15:0]        btn_reg;
    logic               valid_reg;
    logic [15:0]        bits_reg;
    logic signed [15:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic [14:0]        ll_reg, rl_reg;

    assign pop      = (state_reg == B_IDLE) && q_valid;
    assign all_done = !(lbusy || rbusy || tbusy);

    gpn_stick u_left (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pop),
        .x     (q_item.lx),
        .y     (q_item.ly),
        .dz    (left_dz),
        .busy  (lbusy),
        .ox    (lx),
        .oy    (ly)
    );

    gpn_stick u_right (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pop),
        .x     (q_item.rx),
        .y     (q_item.ry),
        .dz    (right_dz),
        .busy  (rbusy),
        .ox    (rx),
        .oy    (ry)
    );

    gpn_trig u_trig (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (pop),
        .ldiff  (q_item.ldiff),
        .rdiff  (q_item.rdiff),
        .span   (q_item.span),
        .busy   (tbusy),
        .llevel (ll),
        .rlevel (rl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == B_RUN) && all_done;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (q_valid) state_next = B_RUN;
            B_RUN:   if (all_done) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            btn_reg <= q_item.buttons;
        end
        if ((state_reg == B_RUN) && all_done)
        begin
            bits_reg <= btn_reg;
            lx_reg   <= lx;
            ly_reg   <= ly;
            rx_reg   <= rx;
            ry_reg   <= ry;
            ll_reg   <= ll;
            rl_reg   <= rl;
        end
    end

    assign result_valid        = valid_reg;
    assign button_bits         = bits_reg;
    assign left_x              = lx_reg;
    assign left_y              = ly_reg;
    assign right_x             = rx_reg;
    assign right_y             = ry_reg;
    assign left_trigger_level  = ll_reg;
    assign right_trigger_level = rl_reg;

    a_idle_engines: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE) |-> !(lbusy || rbusy || tbusy))
        else $error("engine busy while back end idle");

    a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == B_RUN))
        else $error("result without a finished request");

    a_run_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == B_RUN))
        else $error("popped request not started");

endmodule
